FILE: rtl/core/pls_pkg.sv
// Shared types and codes for the positional list store.
`timescale 1ns / 1ps

package pls_pkg;

	// Widest cell index the block supports (up to 64 cells).
	localparam int unsigned IDX_W = 6;
	localparam int unsigned DATA_W = 32;

	// Request codes.
	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_INS_AT    = 3'd2,
		OP_DEL_FRONT = 3'd3,
		OP_DEL_BACK  = 3'd4,
		OP_DEL_AT    = 3'd5,
		OP_READ_ALL  = 3'd6,
		OP_NONE      = 3'd7
	} op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_BADPOS = 2'd1,
		STAT_FULL   = 2'd2,
		STAT_EMPTY  = 2'd3
	} status_t;

	// What every cell of the chain does in one cycle.
	typedef enum logic [1:0] {
		CMD_HOLD = 2'd0,
		CMD_INS  = 2'd1,
		CMD_DEL  = 2'd2,
		CMD_ROT  = 2'd3
	} cmd_kind_t;

	// Command broadcast to all cells.
	typedef struct packed {
		cmd_kind_t          kind;
		logic [IDX_W-1:0]   idx;
		logic [DATA_W-1:0]  value;
	} cell_cmd_t;

endpackage

FILE: rtl/core/pls_cell.sv
// One storage cell of the list chain.
`timescale 1ns / 1ps

module pls_cell
	import pls_pkg::*;
#(
	parameter int unsigned IDX = 0
) (
	input  logic              clk,
	input  cell_cmd_t         cmd,
	input  logic [DATA_W-1:0] prev_d,
	input  logic [DATA_W-1:0] next_d,
	input  logic [DATA_W-1:0] front_d,
	output logic [DATA_W-1:0] q
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] data_d;

	// Pick this cell's next content from the broadcast command.
	always_comb begin
		data_d = data_q;
		case (cmd.kind)
			CMD_INS: begin
				if (MY_IDX > cmd.idx) begin
					data_d = prev_d;
				end else if (MY_IDX == cmd.idx) begin
					data_d = cmd.value;
				end
			end
			CMD_DEL: begin
				if (MY_IDX >= cmd.idx) begin
					data_d = next_d;
				end
			end
			CMD_ROT: begin
				// The last occupied cell wraps around to the front entry.
				if (MY_IDX == cmd.idx) begin
					data_d = front_d;
				end else if (MY_IDX < cmd.idx) begin
					data_d = next_d;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	// Payload register, no reset needed.
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign q = data_q;

endmodule

FILE: rtl/core/positional_list_store.sv
// Top level of the positional list store: request decode, cell chain, result register.
`timescale 1ns / 1ps
//
// Keeps an ordered list of up to DEPTH signed 32-bit values in a chain of cells.
// Requests arrive on the s_ group: s_tuser carries the operation code, s_tdata
// the value and the 1-based position. Results leave on the m_ group: m_tuser is
// the status, m_tdata the new count and the read-out element, m_tlast marks the
// final result of a request.
// Insert and delete requests shift the cells behind the target slot by one as
// they are taken; their one result sits in the output register in the cycle after
// the request is taken, and a new request is taken in every cycle the output
// register is free, so these run at one request per cycle.
// Read-all first enters the read state and then emits one element per cycle,
// while the output register is free, by rotating the chain towards the front;
// this leaves the list in its original order. An empty list gives one result.
// No request is taken during a read-all.
// When the receiver stalls, the result holds in the output register and the
// chain and request side wait with it.
// Reset empties the list and clears any pending result; the cell contents are
// not cleared, since only occupied cells are ever read.
//
module positional_list_store
	import pls_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // value [31:0], position [38:32], zero [39]
	input  logic [2:0]  s_tuser,   // op [2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // count [6:0], item [38:7], zero [39]
	output logic [1:0]  m_tuser,   // status [1:0]
	output logic        m_tlast
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned IW = $clog2(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     rd_q;
	logic              m_tvalid_q;
	status_t           status_q;
	logic [6:0]        count_out_q;
	logic [DATA_W-1:0] item_q;
	logic              last_q;

	logic              out_free;
	logic              accept;
	logic              rd_step;
	logic              load_out;
	op_t               op;
	logic [DATA_W-1:0] in_value;
	logic [7:0]        pos8;
	logic [7:0]        cnt8;
	status_t           req_status;
	logic [CW-1:0]     req_count;
	cell_cmd_t         req_cmd;
	cell_cmd_t         cmd;
	logic              start_read;

	logic [DATA_W-1:0] cell_q [DEPTH];

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept = s_tvalid && s_tready;
	assign rd_step = (state_q == S_READ) && out_free;
	assign load_out = (accept && !start_read) || rd_step;

	assign op = op_t'(s_tuser);
	assign in_value = s_tdata[31:0];
	assign pos8 = {1'b0, s_tdata[38:32]};
	assign cnt8 = 8'(count_q);

	// Decode one request against the current count.
	always_comb begin
		req_status = STAT_OK;
		req_count = count_q;
		start_read = 1'b0;
		req_cmd.kind = CMD_HOLD;
		req_cmd.idx = '0;
		req_cmd.value = in_value;
		case (op)
			OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
				if (op == OP_INS_AT && (pos8 == 8'd0 || pos8 > cnt8 + 8'd1)) begin
					req_status = STAT_BADPOS;
				end else if (count_q >= DEPTH_C) begin
					req_status = STAT_FULL;
				end else begin
					req_cmd.kind = CMD_INS;
					req_count = count_q + CW'(1);
					if (op == OP_INS_BACK) begin
						req_cmd.idx = IDX_W'(count_q);
					end else if (op == OP_INS_AT) begin
						req_cmd.idx = IDX_W'(pos8 - 8'd1);
					end
				end
			end
			OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
				if (count_q == '0) begin
					req_status = STAT_EMPTY;
				end else if (op == OP_DEL_AT && (pos8 == 8'd0 || pos8 > cnt8)) begin
					req_status = STAT_BADPOS;
				end else begin
					req_cmd.kind = CMD_DEL;
					req_count = count_q - CW'(1);
					if (op == OP_DEL_BACK) begin
						req_cmd.idx = IDX_W'(count_q - CW'(1));
					end else if (op == OP_DEL_AT) begin
						req_cmd.idx = IDX_W'(pos8 - 8'd1);
					end
				end
			end
			OP_READ_ALL: begin
				if (count_q == '0) begin
					req_status = STAT_EMPTY;
				end else begin
					start_read = 1'b1;
				end
			end
			default: begin
				req_status = STAT_OK;
			end
		endcase
	end

	// Command for the chain: a request update or one read-out rotation step.
	always_comb begin
		cmd = req_cmd;
		if (rd_step) begin
			cmd.kind = CMD_ROT;
			cmd.idx = IDX_W'(count_q - CW'(1));
		end else if (!accept) begin
			cmd.kind = CMD_HOLD;
		end
	end

	// Chain of cells, each wired to its neighbors and to the front cell.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DATA_W-1:0] prev_w;
		logic [DATA_W-1:0] next_w;
		if (g == 0) begin : g_first
			assign prev_w = cmd.value;
		end else begin : g_mid_prev
			assign prev_w = cell_q[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign next_w = cell_q[g];
		end else begin : g_mid_next
			assign next_w = cell_q[g+1];
		end
		pls_cell #(
			.IDX(g)
		) u_cell (
			.clk    (clk),
			.cmd    (cmd),
			.prev_d (prev_w),
			.next_d (next_w),
			.front_d(cell_q[0]),
			.q      (cell_q[g])
		);
	end

	// Control state, count and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rd_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						count_q <= req_count;
						rd_q <= '0;
						if (start_read) begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					if (rd_step) begin
						rd_q <= rd_q + IW'(1);
						if (CW'(rd_q) == count_q - CW'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload, loaded whenever a new result enters the register.
	always_ff @(posedge clk) begin
		if (accept && !start_read) begin
			status_q <= req_status;
			count_out_q <= 7'(req_count);
			item_q <= '0;
			last_q <= 1'b1;
		end else if (rd_step) begin
			status_q <= STAT_OK;
			count_out_q <= 7'(count_q);
			item_q <= cell_q[0];
			last_q <= (CW'(rd_q) == count_q - CW'(1));
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {1'b0, item_q, count_out_q};
	assign m_tuser = status_q;
	assign m_tlast = last_q;

`ifndef NO_ASSERTIONS
	// The list never holds more than DEPTH entries.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("list count above depth");

	// An empty status always reports a zero count.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == STAT_EMPTY) |-> (m_tdata[6:0] == 7'd0))
		else $error("empty status with nonzero count");

	// The count changes only when a request is taken.
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("count changed without a request");

	// No request is taken while a read-out runs.
	a_read_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> !s_tready)
		else $error("request taken during read-out");
`endif

endmodule

FILE: tb/tb_positional_list_store.sv
// Testbench for the positional list store, checked against a shadow list.
`timescale 1ns / 1ps

module tb_positional_list_store;
	import pls_pkg::*;

	localparam int unsigned LIST_DEPTH = 16;

	// One result as it leaves the block.
	typedef struct packed {
		status_t     status;
		logic [6:0]  count;
		logic [31:0] item;
		logic        last;
	} list_result_t;

	// Shadow copy of the list plus the results it still owes.
	class list_mirror;
		logic [31:0]  cells [LIST_DEPTH];
		int unsigned  fill;
		list_result_t awaited [$];
		int unsigned  errors;
		int unsigned  requests;
		int unsigned  results;
		int unsigned  reads;
		int unsigned  refusals;

		function void queue_result(status_t st, logic [31:0] item, logic last);
			list_result_t r;
			r.status = st;
			r.count = 7'(fill);
			r.item = item;
			r.last = last;
			awaited.push_back(r);
		endfunction

		// Open a gap at the slot by moving the entries behind it back by one.
		function void put_cell(int unsigned slot, logic [31:0] v);
			for (int unsigned i = fill; i > slot; i--)
				cells[i] = cells[i - 1];
			cells[slot] = v;
			fill++;
		endfunction

		// Close the slot by moving the entries behind it forward by one.
		function void drop_cell(int unsigned slot);
			for (int unsigned i = slot; i + 1 < fill; i++)
				cells[i] = cells[i + 1];
			fill--;
		endfunction

		// Apply one accepted request and queue the results it must produce.
		function void take_request(op_t op, logic [31:0] v, logic [6:0] p);
			status_t st;
			st = STAT_OK;
			requests++;
			case (op)
				OP_INS_FRONT, OP_INS_BACK: begin
					if (fill >= LIST_DEPTH)
						st = STAT_FULL;
					else
						put_cell((op == OP_INS_FRONT) ? 0 : fill, v);
				end
				OP_INS_AT: begin
					if (p < 1 || p > fill + 1)
						st = STAT_BADPOS;
					else if (fill >= LIST_DEPTH)
						st = STAT_FULL;
					else
						put_cell(p - 1, v);
				end
				OP_DEL_FRONT, OP_DEL_BACK: begin
					if (fill == 0)
						st = STAT_EMPTY;
					else
						drop_cell((op == OP_DEL_FRONT) ? 0 : fill - 1);
				end
				OP_DEL_AT: begin
					if (fill == 0)
						st = STAT_EMPTY;
					else if (p < 1 || p > fill)
						st = STAT_BADPOS;
					else
						drop_cell(p - 1);
				end
				OP_READ_ALL: begin
					reads++;
					if (fill == 0) begin
						queue_result(STAT_EMPTY, '0, 1'b1);
					end else begin
						for (int unsigned i = 0; i < fill; i++)
							queue_result(STAT_OK, cells[i], (i + 1 == fill));
					end
					return;
				end
				default: ;
			endcase
			if (st == STAT_FULL)
				refusals++;
			queue_result(st, '0, 1'b1);
		endfunction

		function void report(string field, logic [31:0] want, logic [31:0] got);
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h",
				$time, field, want, got);
		endfunction

		// Compare one delivered result with the oldest one owed.
		function void match_result(list_result_t got);
			list_result_t want;
			results++;
			if (awaited.size() == 0) begin
				errors++;
				$display({"%0t: unexpected result, expected none, ",
					"actual status %0d count %0d item %0h last %0b"},
					$time, got.status, got.count, got.item, got.last);
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status)
				report("status", 32'(want.status), 32'(got.status));
			if (got.count !== want.count)
				report("count", 32'(want.count), 32'(got.count));
			if (got.item !== want.item)
				report("item", want.item, got.item);
			if (got.last !== want.last)
				report("last", 32'(want.last), 32'(got.last));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // value [31:0], position [38:32], zero [39]
	logic [2:0]  s_tuser;   // op [2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // count [6:0], item [38:7], zero [39]
	logic [1:0]  m_tuser;   // status [1:0]
	logic        m_tlast;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_trigger;
	bit          grow;
	list_mirror  mirror;

	positional_list_store #(
		.DEPTH(LIST_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#(64'd5_000_000);
		$display("end of test: mismatches");
		$finish;
	end

	// Offer one request from a falling edge and hold it until it is taken.
	task automatic send_request(input op_t op, input logic [31:0] v, input logic [6:0] p);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, p, v};
		do
			@(posedge clk);
		while (!s_tready);
		mirror.take_request(op, v, p);
		@(negedge clk);
	endtask

	// Random requests, mostly sensible ones that sweep the list between empty and full.
	task automatic random_mix(input int unsigned n);
		op_t         op;
		logic [31:0] v;
		logic [6:0]  p;
		int unsigned r;
		repeat (n) begin
			if ($urandom_range(4) == 0) begin
				case ($urandom_range(3))
					0: v = 32'h0000_0000;
					1: v = 32'h8000_0000;
					2: v = 32'h7FFF_FFFF;
					default: v = 32'hFFFF_FFFF;
				endcase
			end else begin
				v = $urandom();
			end
			r = $urandom_range(99);
			if (r < 10) begin
				op = op_t'($urandom_range(7));
				p = 7'($urandom_range(127));
			end else begin
				if (mirror.fill == LIST_DEPTH && $urandom_range(1) == 1)
					grow = 1'b0;
				else if (mirror.fill == 0)
					grow = 1'b1;
				r = $urandom_range(99);
				if (r < 12)
					op = OP_READ_ALL;
				else if ((r < 70) == grow)
					op = op_t'($urandom_range(2));
				else
					op = op_t'($urandom_range(5, 3));
				if (op == OP_INS_AT)
					p = 7'($urandom_range(mirror.fill + 1, 1));
				else
					p = 7'($urandom_range((mirror.fill > 0) ? mirror.fill : 1, 1));
				if ($urandom_range(9) == 0)
					p = 7'($urandom_range(127));
			end
			send_request(op, v, p);
		end
	endtask

	// Result side: check at the rising edge, choose tready for the next cycle.
	initial begin
		int unsigned  hold_left;
		int unsigned  hold_seen;
		logic         ready_next;
		list_result_t got;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = '{status_t'(m_tuser), m_tdata[6:0], m_tdata[38:7], m_tlast};
				mirror.match_result(got);
			end
			if (hold_trigger != hold_seen) begin
				hold_seen = hold_trigger;
				hold_left = 250;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else begin
				ready_next = ($urandom_range(99) >= recv_stall_pct);
			end
			@(negedge clk);
			m_tready <= ready_next;
		end
	end

	// Request side and run control.
	initial begin
		mirror = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_NONE;
		m_tready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_trigger = 0;
		grow = 1'b1;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty list: every delete and read-out gives empty, each insert a bad position.
		send_request(OP_READ_ALL, 32'h0, 7'd0);
		send_request(OP_DEL_FRONT, 32'h0, 7'd0);
		send_request(OP_DEL_BACK, 32'h0, 7'd0);
		send_request(OP_DEL_AT, 32'h0, 7'd1);
		send_request(OP_INS_AT, 32'h1234_5678, 7'd0);
		send_request(OP_INS_AT, 32'h1234_5678, 7'd2);

		// A few entries with extreme values, then positions outside the range.
		send_request(OP_INS_AT, 32'h7FFF_FFFF, 7'd1);
		send_request(OP_INS_FRONT, 32'h8000_0000, 7'd127);
		send_request(OP_INS_BACK, 32'hFFFF_FFFF, 7'd0);
		send_request(OP_INS_AT, 32'h0000_0000, 7'd4);
		send_request(OP_READ_ALL, 32'hFFFF_FFFF, 7'd127);
		send_request(OP_DEL_AT, 32'h0, 7'd0);
		send_request(OP_DEL_AT, 32'h0, 7'd5);
		send_request(OP_DEL_AT, 32'h0, 7'd127);
		send_request(OP_INS_AT, 32'h5555_AAAA, 7'd127);
		send_request(OP_NONE, 32'hFFFF_FFFF, 7'd127);

		// Drain down to empty, ending with a back delete on a single entry.
		send_request(OP_DEL_AT, 32'h0, 7'd2);
		send_request(OP_DEL_FRONT, 32'h0, 7'd0);
		send_request(OP_DEL_BACK, 32'h0, 7'd0);
		send_request(OP_DEL_BACK, 32'h0, 7'd0);
		send_request(OP_READ_ALL, 32'h0, 7'd0);

		// Fill to capacity while the receiver holds off, then push against the full list.
		hold_trigger++;
		while (mirror.fill < LIST_DEPTH)
			send_request(op_t'($urandom_range(2)), $urandom(),
				7'($urandom_range(mirror.fill + 1, 1)));
		send_request(OP_INS_BACK, $urandom(), 7'd0);
		send_request(OP_INS_AT, $urandom(), 7'(LIST_DEPTH + 1));
		send_request(OP_INS_AT, $urandom(), 7'(LIST_DEPTH + 2));
		send_request(OP_INS_FRONT, $urandom(), 7'd0);
		send_request(OP_READ_ALL, 32'h0, 7'd0);
		random_mix(27);

		// Sender idles often.
		send_idle_pct = 63;
		random_mix(27);

		// Receiver stalls often.
		send_idle_pct = 0;
		recv_stall_pct = 63;
		random_mix(27);

		// Both sides idle now and then.
		send_idle_pct = 20;
		recv_stall_pct = 20;
		random_mix(27);

		s_tvalid <= 1'b0;
		while (mirror.awaited.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Run covered %0d requests and %0d results, %0d read-outs,",
			mirror.requests, mirror.results, mirror.reads);
		$display("with %0d inserts refused on a full list.", mirror.refusals);
		if (mirror.errors == 0 && mirror.awaited.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/core/pls_pkg.sv
rtl/core/pls_cell.sv
rtl/core/positional_list_store.sv
tb/tb_positional_list_store.sv
